// ===== rtl/jst_pkg.sv =====
// Shared types and constants of the JSON stream tokenizer.
// No dependencies; the lexer, the top level and the testbench import this package.
`default_nettype none

package jst_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         token_kind;
		logic signed [31:0] token_value;
		logic [2:0]         error_kind;
		logic               last_result;
	} out_item_t;

	// Up to three tokens can come from one input byte.
	localparam int unsigned MaxResults = 3;

	typedef struct packed {
		logic [1:0]                     count;
		out_item_t [MaxResults-1:0]     res;
	} grp_t;

	localparam logic [2:0] KIND_SPECIAL  = 3'd0;
	localparam logic [2:0] KIND_STR_BYTE = 3'd1;
	localparam logic [2:0] KIND_STR_END  = 3'd2;
	localparam logic [2:0] KIND_INTEGER  = 3'd3;
	localparam logic [2:0] KIND_BOOLEAN  = 3'd4;
	localparam logic [2:0] KIND_NULL     = 3'd5;
	localparam logic [2:0] KIND_ERROR    = 3'd6;
	localparam logic [2:0] KIND_DONE     = 3'd7;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
	localparam logic [2:0] ERR_PERIOD     = 3'd2;
	localparam logic [2:0] ERR_MINUS      = 3'd3;
	localparam logic [2:0] ERR_RANGE      = 3'd4;
	localparam logic [2:0] ERR_OPEN_STR   = 3'd5;

endpackage : jst_pkg

`default_nettype wire

// ===== rtl/jst_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Used for both the byte input and the token output of the tokenizer.
`default_nettype none

interface jst_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface : jst_stream_if

`default_nettype wire

// ===== rtl/jst_lexer.sv =====
// Lexer state and the single-pass decode of one byte into up to three tokens.
// Depends on jst_pkg; instantiated by json_stream_tokenizer_top.
`default_nettype none

module jst_lexer
	import jst_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     take,
	input  wire in_item_t item,
	output grp_t          grp
);

	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_STRING  = 2'd1;
	localparam logic [1:0] MODE_NUMBER  = 2'd2;
	localparam logic [1:0] MODE_KEYWORD = 2'd3;

	localparam int FL_PERIOD = 0;
	localparam int FL_MINUS  = 1;
	localparam int FL_NEG    = 2;
	localparam int FL_STOP   = 3;
	localparam int FL_FRAC   = 4;
	localparam int FL_OVER   = 5;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_LBRC   = 8'h7B;
	localparam logic [7:0] CH_RBRC   = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;

	localparam logic [1:0] KW_TRUE  = 2'd0;
	localparam logic [1:0] KW_FALSE = 2'd1;
	localparam logic [1:0] KW_NULL  = 2'd2;

	localparam logic [35:0] LIMIT_MAG = 36'h0_8000_0000;

	function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		case (id)
			KW_TRUE: begin
				case (pos)
					3'd0: ch = 8'h74;
					3'd1: ch = 8'h72;
					3'd2: ch = 8'h75;
					3'd3: ch = 8'h65;
					default: ch = 8'h00;
				endcase
			end
			KW_FALSE: begin
				case (pos)
					3'd0: ch = 8'h66;
					3'd1: ch = 8'h61;
					3'd2: ch = 8'h6C;
					3'd3: ch = 8'h73;
					3'd4: ch = 8'h65;
					default: ch = 8'h00;
				endcase
			end
			default: begin
				case (pos)
					3'd0: ch = 8'h6E;
					3'd1: ch = 8'h75;
					3'd2: ch = 8'h6C;
					3'd3: ch = 8'h6C;
					default: ch = 8'h00;
				endcase
			end
		endcase
		return ch;
	endfunction

	function automatic logic [2:0] kw_len(input logic [1:0] id);
		return (id == KW_FALSE) ? 3'd5 : 3'd4;
	endfunction

	logic [1:0]  mode_q, mode;
	logic [1:0]  kid_q, kid;
	logic [2:0]  kpos_q, kpos;
	logic [31:0] mag_q, mag;
	logic [5:0]  flags_q, flags;
	logic        err_q, err;

	logic [1:0]  n;
	out_item_t [MaxResults-1:0] res;
	logic        run_idle, run_num, first, is_num, fin_bad;
	logic [7:0]  c;
	logic [35:0] v;

	assign c      = item.char_code;
	assign is_num = (c > 8'h2F && c < 8'h3A) || c == CH_PERIOD || c == CH_MINUS;

	always_comb begin
		mode     = mode_q;
		kid      = kid_q;
		kpos     = kpos_q;
		mag      = mag_q;
		flags    = flags_q;
		err      = err_q;
		n        = 2'd0;
		res      = '0;
		run_idle = 1'b0;
		run_num  = 1'b0;
		first    = 1'b0;
		fin_bad  = 1'b0;
		v        = '0;

		if (!err) begin
			unique case (mode)
				MODE_STRING: begin
					if (c == CH_QUOTE) begin
						res[n] = '{KIND_STR_END, 32'sd0, ERR_NONE, 1'b0};
						n = n + 2'd1;
						mode = MODE_IDLE;
					end else begin
						res[n] = '{KIND_STR_BYTE, {24'd0, c}, ERR_NONE, 1'b0};
						n = n + 2'd1;
					end
				end
				MODE_NUMBER: begin
					if (is_num) begin
						run_num = 1'b1;
					end else begin
						// The number ends here; unless it is out of range, the byte is then handled as in idle.
						mode = MODE_IDLE;
						fin_bad = flags[FL_FRAC] || flags[FL_OVER] ||
							(!flags[FL_NEG] && mag[31]);
						if (fin_bad) begin
							res[n] = '{KIND_ERROR, 32'sd0, ERR_RANGE, 1'b0};
							n = n + 2'd1;
							err = 1'b1;
						end else begin
							res[n] = '{KIND_INTEGER, flags[FL_NEG] ? -mag : mag,
								ERR_NONE, 1'b0};
							n = n + 2'd1;
							run_idle = 1'b1;
						end
					end
				end
				MODE_KEYWORD: begin
					if (kpos >= kw_len(kid) || kw_char(kid, kpos) != c) begin
						res[n] = '{KIND_ERROR, 32'sd0, ERR_UNEXPECTED, 1'b0};
						n = n + 2'd1;
						err = 1'b1;
						mode = MODE_IDLE;
					end else begin
						kpos = kpos + 3'd1;
						if (kpos == kw_len(kid)) begin
							mode = MODE_IDLE;
							kpos = 3'd0;
							if (kid == KW_TRUE) begin
								res[n] = '{KIND_BOOLEAN, 32'sd1, ERR_NONE, 1'b0};
							end else if (kid == KW_FALSE) begin
								res[n] = '{KIND_BOOLEAN, 32'sd0, ERR_NONE, 1'b0};
							end else begin
								res[n] = '{KIND_NULL, 32'sd0, ERR_NONE, 1'b0};
							end
							n = n + 2'd1;
						end
					end
				end
				MODE_IDLE: begin
					run_idle = 1'b1;
				end
			endcase
		end

		if (run_idle) begin
			if (c == CH_QUOTE) begin
				mode = MODE_STRING;
			end else if (is_num) begin
				mode    = MODE_NUMBER;
				flags   = '0;
				mag     = '0;
				run_num = 1'b1;
				first   = 1'b1;
			end else if (c == CH_T || c == CH_F || c == CH_N) begin
				mode = MODE_KEYWORD;
				kid  = (c == CH_T) ? KW_TRUE : (c == CH_F) ? KW_FALSE : KW_NULL;
				kpos = 3'd1;
			end else if (c == CH_LBRK || c == CH_RBRK || c == CH_LBRC || c == CH_RBRC ||
				c == CH_COLON || c == CH_COMMA) begin
				res[n] = '{KIND_SPECIAL, {24'd0, c}, ERR_NONE, 1'b0};
				n = n + 2'd1;
			end else if (c == CH_SPACE || c == CH_NL) begin
				mode = mode;
			end else begin
				res[n] = '{KIND_ERROR, 32'sd0, ERR_UNEXPECTED, 1'b0};
				n = n + 2'd1;
				err = 1'b1;
				mode = MODE_IDLE;
			end
		end

		if (run_num) begin
			if (c == CH_PERIOD) begin
				if (flags[FL_PERIOD]) begin
					res[n] = '{KIND_ERROR, 32'sd0, ERR_PERIOD, 1'b0};
					n = n + 2'd1;
					err = 1'b1;
					mode = MODE_IDLE;
				end else begin
					flags[FL_PERIOD] = 1'b1;
				end
			end else if (c == CH_MINUS) begin
				if (flags[FL_MINUS]) begin
					res[n] = '{KIND_ERROR, 32'sd0, ERR_MINUS, 1'b0};
					n = n + 2'd1;
					err = 1'b1;
					mode = MODE_IDLE;
				end else begin
					flags[FL_MINUS] = 1'b1;
					// A leading minus is the sign; a later one stops the conversion.
					if (first) begin
						flags[FL_NEG] = 1'b1;
					end else begin
						flags[FL_STOP] = 1'b1;
					end
				end
			end else if (!flags[FL_STOP]) begin
				if (flags[FL_PERIOD]) begin
					if (c[3:0] != 4'd0) begin
						flags[FL_FRAC] = 1'b1;
					end
				end else if (!flags[FL_OVER]) begin
					v = ({4'd0, mag} << 3) + ({4'd0, mag} << 1) + {32'd0, c[3:0]};
					if (v > LIMIT_MAG) begin
						flags[FL_OVER] = 1'b1;
						v = LIMIT_MAG;
					end
					mag = v[31:0];
				end
			end
		end

		if (item.end_of_input) begin
			if (!err) begin
				if (mode == MODE_NUMBER) begin
					fin_bad = flags[FL_FRAC] || flags[FL_OVER] ||
						(!flags[FL_NEG] && mag[31]);
					if (fin_bad) begin
						res[n] = '{KIND_ERROR, 32'sd0, ERR_RANGE, 1'b0};
						err = 1'b1;
					end else begin
						res[n] = '{KIND_INTEGER, flags[FL_NEG] ? -mag : mag,
							ERR_NONE, 1'b0};
					end
					n = n + 2'd1;
				end else if (mode == MODE_STRING) begin
					res[n] = '{KIND_ERROR, 32'sd0, ERR_OPEN_STR, 1'b0};
					n = n + 2'd1;
					err = 1'b1;
				end else if (mode == MODE_KEYWORD) begin
					res[n] = '{KIND_ERROR, 32'sd0, ERR_UNEXPECTED, 1'b0};
					n = n + 2'd1;
					err = 1'b1;
				end
			end
			res[n] = '{KIND_DONE, {31'd0, err}, ERR_NONE, 1'b0};
			n = n + 2'd1;
			mode  = MODE_IDLE;
			kid   = KW_TRUE;
			kpos  = 3'd0;
			mag   = '0;
			flags = '0;
			err   = 1'b0;
		end
	end

	assign grp.count = n;
	assign grp.res   = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			kid_q   <= KW_TRUE;
			kpos_q  <= 3'd0;
			mag_q   <= '0;
			flags_q <= '0;
			err_q   <= 1'b0;
		end else if (take) begin
			mode_q  <= mode;
			kid_q   <= kid;
			kpos_q  <= kpos;
			mag_q   <= mag;
			flags_q <= flags;
			err_q   <= err;
		end
	end

endmodule : jst_lexer

`default_nettype wire

// ===== rtl/json_stream_tokenizer_top.sv =====
// Top level of the JSON stream tokenizer: lexer, token group register and output register.
// Depends on jst_pkg, jst_stream_if and jst_lexer.
//
// The block takes one byte of JSON text per cycle and gives tokens one per cycle while
// the receiver is ready. A byte that yields at most one token does not hold the input,
// so plain text and strings stream at one item per cycle. A byte that yields several
// tokens (up to three: a number closed by a structural character at the end marker)
// holds the input until its last token moves on, because the single output port sends
// the tokens of a group one after another. The lexer state is updated in the cycle a
// byte is taken; the group register then lets the next byte in while a finished token
// waits in the output register.
`default_nettype none

module json_stream_tokenizer_top
	import jst_pkg::*;
(
	input wire logic   clk,
	input wire logic   arst_n,
	jst_stream_if.sink   text,
	jst_stream_if.source tokens
);

	grp_t       grp;
	grp_t       grp_s1;
	logic       grp_valid_s1;
	logic [1:0] idx_s1;
	out_item_t  out_q;
	out_item_t  out_next;
	logic       out_valid_q;
	logic       take, out_load, grp_last, grp_done;

	jst_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (text.payload),
		.grp    (grp)
	);

	assign out_load   = grp_valid_s1 && (!out_valid_q || tokens.ready);
	assign grp_last   = (idx_s1 == grp_s1.count - 2'd1);
	assign grp_done   = out_load && grp_last;
	assign text.ready = !grp_valid_s1 || grp_done;
	assign take       = text.valid && text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_s1 <= 1'b0;
			idx_s1       <= 2'd0;
		end else if (take) begin
			grp_valid_s1 <= (grp.count != 2'd0);
			idx_s1       <= 2'd0;
		end else if (grp_done) begin
			grp_valid_s1 <= 1'b0;
		end else if (out_load) begin
			idx_s1 <= idx_s1 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			grp_s1 <= grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (tokens.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		out_next             = grp_s1.res[idx_s1];
		out_next.last_result = grp_last;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
	end

	assign tokens.valid   = out_valid_q;
	assign tokens.payload = out_q;

endmodule : json_stream_tokenizer_top

`default_nettype wire

// ===== dv/json_stream_tokenizer_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench of json_stream_tokenizer_top: directed and random JSON documents with a token predictor.
// Depends on jst_pkg, jst_stream_if and the tokenizer RTL.

module json_stream_tokenizer_top_tb;
	import jst_pkg::*;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_STRING, SCAN_NUMBER, SCAN_KEYWORD} lex_mode_e;
	typedef enum logic [1:0] {KW_TRUE, KW_FALSE, KW_NULL} keyword_e;
	typedef enum logic [1:0] {
		PH_STEADY, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH_IDLE
	} idle_phase_e;

	localparam logic [7:0] CH_QUOTE   = "\"";
	localparam logic [7:0] CH_PERIOD  = ".";
	localparam logic [7:0] CH_MINUS   = "-";
	localparam logic [7:0] CH_SPACE   = " ";
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_COLON   = ":";
	localparam logic [7:0] CH_COMMA   = ",";
	localparam logic [7:0] CH_LBRACK  = "[";
	localparam logic [7:0] CH_RBRACK  = "]";
	localparam logic [7:0] CH_LBRACE  = "{";
	localparam logic [7:0] CH_RBRACE  = "}";
	localparam logic [7:0] CH_DIGIT0  = "0";
	localparam logic [7:0] CH_DIGIT9  = "9";
	localparam logic [7:0] CH_BSLASH  = "\\";
	localparam int BUSY_PCT    = 65;
	localparam int LIGHT_PCT   = 16;
	localparam int PHASE_BYTES = 105;
	localparam int TAIL_CYCLES = 20;
	localparam int CYCLE_LIMIT = 100000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	jst_stream_if #(.payload_t(in_item_t))  text_ch ();
	jst_stream_if #(.payload_t(out_item_t)) token_ch ();

	json_stream_tokenizer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.tokens (token_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	in_item_t    bytes_to_send[$];
	out_item_t   tokens_due[$];
	logic [7:0]  doc_buf[$];
	idle_phase_e idle_phase = PH_STEADY;
	int          mismatch_count = 0;
	int          tokens_seen = 0;
	int          cycle_count = 0;

	// Predictor state.
	lex_mode_e   lex_mode;
	keyword_e    kw_sel;
	logic [2:0]  kw_pos;
	logic [31:0] num_mag;
	logic        num_period, num_minus, num_neg, num_stop, num_frac, num_over;
	logic        err_latched;
	int          byte_token_count;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic void clear_lexer();
		lex_mode = SCAN_IDLE;
		kw_sel = KW_TRUE;
		kw_pos = '0;
		num_mag = '0;
		{num_period, num_minus, num_neg, num_stop, num_frac, num_over} = '0;
		err_latched = 1'b0;
	endfunction

	function automatic void put_token(input logic [2:0] kind, input logic [31:0] value,
			input logic [2:0] err);
		out_item_t t;
		t.token_kind = kind;
		t.token_value = value;
		t.error_kind = err;
		t.last_result = 1'b0;
		tokens_due.insert(tokens_due.size(), t);
		byte_token_count++;
	endfunction

	function automatic void raise_error(input logic [2:0] err);
		put_token(KIND_ERROR, 32'd0, err);
		err_latched = 1'b1;
		lex_mode = SCAN_IDLE;
	endfunction

	function automatic logic is_number_char(input logic [7:0] c);
		return (c >= CH_DIGIT0 && c <= CH_DIGIT9) || c == CH_PERIOD || c == CH_MINUS;
	endfunction

	function automatic void number_byte(input logic [7:0] c, input logic first);
		logic [63:0] wide;
		logic [7:0]  d;
		d = c - CH_DIGIT0;
		if (c == CH_PERIOD) begin
			if (num_period) raise_error(ERR_PERIOD);
			else num_period = 1'b1;
		end else if (c == CH_MINUS) begin
			if (num_minus) begin
				raise_error(ERR_MINUS);
			end else begin
				num_minus = 1'b1;
				// Only a leading minus signs the value; a later one stops the conversion.
				if (first) num_neg = 1'b1;
				else num_stop = 1'b1;
			end
		end else if (!num_stop) begin
			if (num_period) begin
				if (d != 8'd0) num_frac = 1'b1;
			end else if (!num_over) begin
				wide = 64'(num_mag) * 64'd10 + 64'(d);
				if (wide > 64'h8000_0000) begin
					num_over = 1'b1;
					wide = 64'h8000_0000;
				end
				num_mag = wide[31:0];
			end
		end
	endfunction

	function automatic void number_finish();
		lex_mode = SCAN_IDLE;
		if (num_frac || num_over || (!num_neg && num_mag > 32'h7FFF_FFFF))
			raise_error(ERR_RANGE);
		else
			put_token(KIND_INTEGER, num_neg ? (32'd0 - num_mag) : num_mag, ERR_NONE);
	endfunction

	function automatic void idle_byte(input logic [7:0] c);
		if (c == CH_QUOTE) begin
			lex_mode = SCAN_STRING;
		end else if (is_number_char(c)) begin
			lex_mode = SCAN_NUMBER;
			{num_period, num_minus, num_neg, num_stop, num_frac, num_over} = '0;
			num_mag = '0;
			number_byte(c, 1'b1);
		end else if (c == "t" || c == "f" || c == "n") begin
			lex_mode = SCAN_KEYWORD;
			if (c == "t") kw_sel = KW_TRUE;
			else if (c == "f") kw_sel = KW_FALSE;
			else kw_sel = KW_NULL;
			kw_pos = 3'd1;
		end else if (c == CH_LBRACK || c == CH_RBRACK || c == CH_LBRACE || c == CH_RBRACE
				|| c == CH_COLON || c == CH_COMMA) begin
			put_token(KIND_SPECIAL, {24'd0, c}, ERR_NONE);
		end else if (c != CH_SPACE && c != CH_NEWLINE) begin
			raise_error(ERR_UNEXPECTED);
		end
	endfunction

	// Works out the tokens that one accepted byte causes and queues them in order.
	function automatic void tokenize_byte(input in_item_t item);
		logic [7:0] c;
		string      word;
		out_item_t  t;
		c = item.char_code;
		byte_token_count = 0;
		if (!err_latched) begin
			case (lex_mode)
				SCAN_STRING: begin
					if (c == CH_QUOTE) begin
						put_token(KIND_STR_END, 32'd0, ERR_NONE);
						lex_mode = SCAN_IDLE;
					end else begin
						put_token(KIND_STR_BYTE, {24'd0, c}, ERR_NONE);
					end
				end
				SCAN_NUMBER: begin
					if (is_number_char(c)) begin
						number_byte(c, 1'b0);
					end else begin
						number_finish();
						if (!err_latched) idle_byte(c);
					end
				end
				SCAN_KEYWORD: begin
					if (kw_sel == KW_TRUE) word = "true";
					else if (kw_sel == KW_FALSE) word = "false";
					else word = "null";
					if (kw_pos >= word.len() || word[kw_pos] != c) begin
						raise_error(ERR_UNEXPECTED);
					end else begin
						kw_pos = kw_pos + 3'd1;
						if (kw_pos == word.len()) begin
							lex_mode = SCAN_IDLE;
							kw_pos = '0;
							case (kw_sel)
								KW_TRUE: put_token(KIND_BOOLEAN, 32'd1, ERR_NONE);
								KW_FALSE: put_token(KIND_BOOLEAN, 32'd0, ERR_NONE);
								default: put_token(KIND_NULL, 32'd0, ERR_NONE);
							endcase
						end
					end
				end
				default: idle_byte(c);
			endcase
		end
		if (item.end_of_input) begin
			if (!err_latched) begin
				if (lex_mode == SCAN_NUMBER) number_finish();
				else if (lex_mode == SCAN_STRING) raise_error(ERR_OPEN_STR);
				else if (lex_mode == SCAN_KEYWORD) raise_error(ERR_UNEXPECTED);
			end
			put_token(KIND_DONE, {31'd0, err_latched}, ERR_NONE);
			clear_lexer();
		end
		if (byte_token_count != 0) begin
			t = tokens_due.pop_back();
			t.last_result = 1'b1;
			tokens_due.insert(tokens_due.size(), t);
		end
	endfunction

	// Document building.
	function automatic void add_byte(input logic [7:0] b);
		doc_buf.insert(doc_buf.size(), b);
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	task automatic add_gap();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE);
	endtask

	task automatic add_number();
		case ($urandom_range(0, 9))
			0, 1, 2: add_text($sformatf("%0d", $urandom_range(0, 999)));
			3: add_text($sformatf("-%0d", $urandom_range(0, 99999)));
			4: add_text($sformatf("%0d", $signed($urandom())));
			5: begin
				case ($urandom_range(0, 6))
					0: add_text("2147483647");
					1: add_text("-2147483648");
					2: add_text("2147483648");
					3: add_text("-2147483649");
					4: add_text("98765432101");
					5: add_text("-0");
					default: add_text("0");
				endcase
			end
			6: begin
				case ($urandom_range(0, 7))
					0: add_text("1.0");
					1: add_text("12.000");
					2: add_text("3.25");
					3: add_text("-0.5");
					4: add_text(".0");
					5: add_text("-.");
					6: add_text(".");
					default: add_text("7.05");
				endcase
			end
			// A minus inside the number stops the conversion of what follows.
			7: begin
				case ($urandom_range(0, 3))
					0: add_text("5-3");
					1: add_text("12-99");
					2: add_text("7.-1");
					default: add_text("6-.2");
				endcase
			end
			8: begin
				case ($urandom_range(0, 4))
					0: add_text("1..2");
					1: add_text("1-2-3");
					2: add_text("--1");
					3: add_text("2.3.");
					default: add_text("-1-");
				endcase
			end
			default: add_text($sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 9)));
		endcase
	endtask

	task automatic add_string();
		int         n;
		logic [7:0] b;
		n = $urandom_range(0, 5);
		add_byte(CH_QUOTE);
		repeat (n) begin
			b = $urandom_range(0, 1) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
			if (b == CH_QUOTE) b = CH_BSLASH;
			add_byte(b);
		end
		add_byte(CH_QUOTE);
	endtask

	task automatic add_scalar();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: add_number();
			6: add_text("true");
			7: add_text("false");
			8: add_text("null");
			default: add_string();
		endcase
	endtask

	task automatic add_member_head(input logic is_obj, input int index);
		if (index > 0) add_byte(CH_COMMA);
		add_gap();
		if (is_obj) begin
			add_string();
			add_gap();
			add_byte(CH_COLON);
			add_gap();
		end
	endtask

	task automatic add_flat_container(input logic is_obj);
		int n;
		n = $urandom_range(0, 3);
		add_byte(is_obj ? CH_LBRACE : CH_LBRACK);
		for (int i = 0; i < n; i++) begin
			add_member_head(is_obj, i);
			add_scalar();
		end
		add_gap();
		add_byte(is_obj ? CH_RBRACE : CH_RBRACK);
	endtask

	task automatic add_nested_container(input logic is_obj);
		int n;
		n = $urandom_range(0, 3);
		add_byte(is_obj ? CH_LBRACE : CH_LBRACK);
		for (int i = 0; i < n; i++) begin
			add_member_head(is_obj, i);
			case ($urandom_range(0, 9))
				7: add_flat_container(1'b0);
				8: add_flat_container(1'b1);
				default: add_scalar();
			endcase
		end
		add_gap();
		add_byte(is_obj ? CH_RBRACE : CH_RBRACK);
	endtask

	task automatic queue_doc();
		in_item_t it;
		for (int i = 0; i < doc_buf.size(); i++) begin
			it.char_code = doc_buf[i];
			it.end_of_input = (i == doc_buf.size() - 1);
			bytes_to_send.insert(bytes_to_send.size(), it);
		end
		doc_buf.delete();
	endtask

	task automatic wait_sent();
		while (bytes_to_send.size() != 0) @(posedge clk);
	endtask

	// Byte driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_ch.valid <= 1'b0;
			text_ch.payload <= '0;
			clear_lexer();
		end else begin
			if (text_ch.valid && text_ch.ready) begin
				tokenize_byte(text_ch.payload);
				void'(bytes_to_send.pop_front());
			end
			if (!text_ch.valid || text_ch.ready) begin
				if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >=
						((idle_phase == PH_SENDER_IDLE) ? BUSY_PCT :
						(idle_phase == PH_BOTH_IDLE) ? LIGHT_PCT : 0)) begin
					text_ch.valid <= 1'b1;
					text_ch.payload <= bytes_to_send[0];
				end else begin
					text_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Token monitor and checker.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_ch.ready <= 1'b0;
		end else begin
			if (token_ch.valid && token_ch.ready) begin
				tokens_seen++;
				if (tokens_due.size() == 0) begin
					report_mismatch($sformatf("token %0d: kind %0d value %0d with nothing expected",
						tokens_seen, token_ch.payload.token_kind, token_ch.payload.token_value));
				end else begin
					if (token_ch.payload.token_kind != tokens_due[0].token_kind)
						report_mismatch($sformatf("token %0d: kind %0d, expected %0d", tokens_seen,
							token_ch.payload.token_kind, tokens_due[0].token_kind));
					if (token_ch.payload.token_value != tokens_due[0].token_value)
						report_mismatch($sformatf("token %0d: value %0d, expected %0d", tokens_seen,
							token_ch.payload.token_value, tokens_due[0].token_value));
					if (token_ch.payload.error_kind != tokens_due[0].error_kind)
						report_mismatch($sformatf("token %0d: error kind %0d, expected %0d",
							tokens_seen, token_ch.payload.error_kind, tokens_due[0].error_kind));
					if (token_ch.payload.last_result != tokens_due[0].last_result)
						report_mismatch($sformatf("token %0d: last flag %0d, expected %0d",
							tokens_seen, token_ch.payload.last_result, tokens_due[0].last_result));
					void'(tokens_due.pop_front());
				end
			end
			token_ch.ready <= $urandom_range(0, 99) >=
				((idle_phase == PH_RECEIVER_STALL) ? BUSY_PCT :
				(idle_phase == PH_BOTH_IDLE) ? LIGHT_PCT : 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("json_stream_tokenizer_top_tb: errors");
			$finish;
		end
	end

	initial begin
		int phase_bytes;
		int pick;
		int keep;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Structural, string bytes at both extremes and a negative number closed by the end.
		add_byte(CH_LBRACE);
		add_byte(CH_QUOTE);
		add_byte(CH_BSLASH);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(CH_QUOTE);
		add_text(":-7");
		queue_doc();
		// Number closed by a structural byte that also ends the input: three tokens.
		add_text("7]");
		queue_doc();
		// A keyword that finishes on the end marker.
		add_text("null");
		queue_doc();
		add_text("..");
		queue_doc();
		add_text("-1-");
		queue_doc();
		// Unfinished keyword and open string at the end.
		add_text("n");
		queue_doc();
		add_byte(CH_QUOTE);
		queue_doc();
		// A zero byte outside a string is unexpected.
		add_byte(8'h00);
		queue_doc();
		// The comma after the error is ignored.
		add_text("?,");
		queue_doc();
		wait_sent();

		for (int p = 0; p < 4; p++) begin
			@(negedge clk);
			idle_phase = idle_phase_e'(p);
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				pick = $urandom_range(0, 99);
				if (pick < 90) begin
					add_gap();
					case ($urandom_range(0, 9))
						6, 7: add_nested_container(1'b0);
						8, 9: add_nested_container(1'b1);
						default: add_scalar();
					endcase
					add_gap();
				end else begin
					repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
				end
				// Some well-formed documents get cut short or have one byte overwritten.
				if (pick >= 78 && pick < 90) begin
					if ($urandom_range(0, 1)) begin
						keep = $urandom_range(1, doc_buf.size());
						while (doc_buf.size() > keep) void'(doc_buf.pop_back());
					end else begin
						doc_buf[$urandom_range(0, doc_buf.size() - 1)] = 8'($urandom_range(0, 255));
					end
				end
				phase_bytes += doc_buf.size();
				queue_doc();
			end
			wait_sent();
		end

		while (tokens_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("json_stream_tokenizer_top_tb: clean");
		end else begin
			$display("json_stream_tokenizer_top_tb: errors");
		end
		$finish;
	end

endmodule
